// File: rtl/pproj_pkg.sv
// Package: constants, types and register indexes for the perspective projection block.
`timescale 1ns / 1ps
package pproj_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int REG_WIDTH       = 32;
    localparam int CFG_IDX_WIDTH   = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_X_SCALE  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Y_SCALE  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Z_SCALE  = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Z_OFFSET = 2'd3;

    localparam logic signed [REG_WIDTH-1:0] X_SCALE_RESET  = 32'sd65536;
    localparam logic signed [REG_WIDTH-1:0] Y_SCALE_RESET  = 32'sd65536;
    localparam logic signed [REG_WIDTH-1:0] Z_SCALE_RESET  = 32'sd65543;
    localparam logic signed [REG_WIDTH-1:0] Z_OFFSET_RESET = -32'sd6554;

    typedef struct packed {
        logic valid;
        logic stall;
    } stage_ctl_t;

endpackage

// File: rtl/pproj_mul.sv
// Scale stage: three products and the depth offset, registered twice.
`timescale 1ns / 1ps
module pproj_mul
    import pproj_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int NUM_WIDTH   = COORD_WIDTH + REG_WIDTH + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [COORD_WIDTH-1:0]  x,
    input  logic signed [COORD_WIDTH-1:0]  y,
    input  logic signed [COORD_WIDTH-1:0]  z,
    input  logic signed [REG_WIDTH-1:0]    x_scale,
    input  logic signed [REG_WIDTH-1:0]    y_scale,
    input  logic signed [REG_WIDTH-1:0]    z_scale,
    input  logic signed [REG_WIDTH-1:0]    z_offset,
    output logic                           out_valid,
    output logic signed [NUM_WIDTH-1:0]    nx,
    output logic signed [NUM_WIDTH-1:0]    ny,
    output logic signed [NUM_WIDTH-1:0]    nz,
    output logic signed [COORD_WIDTH-1:0]  zd
);
    localparam int PW = COORD_WIDTH + REG_WIDTH;

    logic                          v1_reg, v2_reg;
    logic signed [PW-1:0]          px_reg, py_reg, pz_reg;
    logic signed [REG_WIDTH-1:0]   off_reg;
    logic signed [COORD_WIDTH-1:0] z1_reg, z2_reg;
    logic signed [NUM_WIDTH-1:0]   nx_reg, ny_reg, nz_reg;
    logic signed [NUM_WIDTH-1:0]   nz_next;

    always_comb
    begin
        nz_next = NUM_WIDTH'(pz_reg) + (NUM_WIDTH'(off_reg) <<< FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= PW'(x) * PW'(x_scale);
            py_reg  <= PW'(y) * PW'(y_scale);
            pz_reg  <= PW'(z) * PW'(z_scale);
            off_reg <= z_offset;
            z1_reg  <= z;
            nx_reg  <= NUM_WIDTH'(px_reg);
            ny_reg  <= NUM_WIDTH'(py_reg);
            nz_reg  <= nz_next;
            z2_reg  <= z1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign nx = nx_reg;
    assign ny = ny_reg;
    assign nz = nz_reg;
    assign zd = z2_reg;
endmodule

// File: rtl/pproj_div.sv
// Pipelined restoring divider: one quotient bit per stage, sign and saturation at the end.
`timescale 1ns / 1ps
module pproj_div
    import pproj_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int NUM_WIDTH   = COORD_WIDTH + REG_WIDTH + 1
)
(
    input  logic                           clk,
    input  logic                           adv,
    input  logic signed [NUM_WIDTH-1:0]    num,
    input  logic signed [COORD_WIDTH-1:0]  den,
    output logic signed [COORD_WIDTH-1:0]  q
);
    // Only quotient bits up to COORD_WIDTH+1 matter; higher bits force saturation.
    localparam int MW  = NUM_WIDTH - 1;
    localparam int QW  = COORD_WIDTH + 1;
    localparam int RW  = COORD_WIDTH + 1;

    logic [MW-1:0]          mag_reg   [QW+1];
    logic [COORD_WIDTH-1:0] dmag_reg  [QW+1];
    logic                   neg_reg   [QW+1];
    logic                   ovf_reg   [QW+1];
    logic [RW-1:0]          rem_reg   [QW+1];
    logic [QW-1:0]          quo_reg   [QW+1];
    logic signed [COORD_WIDTH-1:0] q_reg;

    logic [MW-1:0]          mag0;
    logic [COORD_WIDTH-1:0] dmag0;
    logic                   ovf0;

    always_comb
    begin
        mag0  = num[NUM_WIDTH-1] ? MW'(-num) : MW'(num);
        dmag0 = den[COORD_WIDTH-1] ? COORD_WIDTH'(-den) : COORD_WIDTH'(den);
        // quotient >= 2^QW iff high part of magnitude >= divisor
        ovf0  = ({{(RW-1){1'b0}}, 1'b0} | RW'(mag0 >> QW)) >= RW'(dmag0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg[0]  <= mag0;
            dmag_reg[0] <= dmag0;
            neg_reg[0]  <= num[NUM_WIDTH-1] ^ den[COORD_WIDTH-1];
            ovf_reg[0]  <= ovf0;
            rem_reg[0]  <= RW'(mag0 >> QW);
            quo_reg[0]  <= '0;
        end
    end

    generate
        for (genvar i = 0; i < QW; i++)
        begin : g_step
            logic [RW:0]   trial;
            logic [RW-1:0] rem_next;
            logic          bit_q;
            always_comb
            begin
                trial    = {rem_reg[i], mag_reg[i][QW-1-i]} - {2'b00, dmag_reg[i]};
                bit_q    = !trial[RW];
                rem_next = bit_q ? trial[RW-1:0]
                                 : RW'({rem_reg[i], mag_reg[i][QW-1-i]});
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    mag_reg[i+1]  <= mag_reg[i];
                    dmag_reg[i+1] <= dmag_reg[i];
                    neg_reg[i+1]  <= neg_reg[i];
                    ovf_reg[i+1]  <= ovf_reg[i];
                    rem_reg[i+1]  <= rem_next;
                    quo_reg[i+1]  <= quo_reg[i] | (QW'(bit_q) << (QW-1-i));
                end
            end
        end
    endgenerate

    localparam logic [QW-1:0] POS_MAX = (QW'(1) << (COORD_WIDTH-1)) - QW'(1);
    localparam logic [QW-1:0] NEG_MAX = QW'(1) << (COORD_WIDTH-1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (neg_reg[QW])
            begin
                if (ovf_reg[QW] || quo_reg[QW] > NEG_MAX)
                    q_reg <= COORD_WIDTH'(NEG_MAX);
                else
                    q_reg <= COORD_WIDTH'(-quo_reg[QW]);
            end
            else
            begin
                if (ovf_reg[QW] || quo_reg[QW] > POS_MAX)
                    q_reg <= COORD_WIDTH'(POS_MAX);
                else
                    q_reg <= COORD_WIDTH'(quo_reg[QW]);
            end
        end
    end

    assign q = q_reg;
endmodule

// File: rtl/perspective_projection.sv
// Perspective projection: the scale stage feeds three pipelined dividers, one per coordinate.
// Throughput: one vertex per cycle; the pipeline advances whenever the output
// register is empty or taken, so a stall holds every stage in place.
// Per-stage depth: one 32x32 multiply, one wide add, or one divider bit step.
// Reset: asynchronous active low; clears valid bits and loads the default
// projection registers (scale 1.0, near 0.1, far 1000).
`timescale 1ns / 1ps
module perspective_projection
    import pproj_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int IN_BYTES    = (3*COORD_WIDTH + 7) / 8,
    parameter int OUT_BYTES   = (3*COORD_WIDTH + 1 + 7) / 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [REG_WIDTH-1:0]       cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_BYTES*8-1:0]      s_axis_tdata,   // in_x, in_y, in_z
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_BYTES*8-1:0]     m_axis_tdata    // proj_x, proj_y, proj_z, depth_zero
);
    localparam int NW  = COORD_WIDTH + REG_WIDTH + 1;
    localparam int DLY = COORD_WIDTH + 3;   // divider stages

    logic signed [REG_WIDTH-1:0] x_scale_reg, y_scale_reg, z_scale_reg, z_offset_reg;
    stage_ctl_t ctl;
    logic adv;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg  <= X_SCALE_RESET;
            y_scale_reg  <= Y_SCALE_RESET;
            z_scale_reg  <= Z_SCALE_RESET;
            z_offset_reg <= Z_OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_SCALE:  x_scale_reg  <= cfg_data;
                REG_Y_SCALE:  y_scale_reg  <= cfg_data;
                REG_Z_SCALE:  z_scale_reg  <= cfg_data;
                REG_Z_OFFSET: z_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    assign ctl.stall = out_valid_reg && !m_axis_tready;
    assign adv = !ctl.stall;
    assign s_axis_tready = adv;

    logic                          mv;
    logic signed [NW-1:0]          nx, ny, nz;
    logic signed [COORD_WIDTH-1:0] zd;

    pproj_mul #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .NUM_WIDTH(NW)) u_mul (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(s_axis_tvalid),
        .x(s_axis_tdata[COORD_WIDTH-1:0]),
        .y(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .z(s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .x_scale(x_scale_reg), .y_scale(y_scale_reg),
        .z_scale(z_scale_reg), .z_offset(z_offset_reg),
        .out_valid(mv), .nx(nx), .ny(ny), .nz(nz), .zd(zd)
    );

    // zero depth: divide by 2^FRAC_BITS; floor via shift equals dividing by one
    // after pre-shift, so feed a shifted numerator and divisor of one.
    logic                          zz;
    logic signed [NW-1:0]          sx, sy, sz, dx, dy, dz;
    logic signed [COORD_WIDTH-1:0] dd;
    always_comb
    begin
        zz = (zd == '0);
        sx = nx >>> FRAC_BITS;
        sy = ny >>> FRAC_BITS;
        sz = nz >>> FRAC_BITS;
        dx = zz ? sx : nx;
        dy = zz ? sy : ny;
        dz = zz ? sz : nz;
        dd = zz ? COORD_WIDTH'(1) : zd;
    end

    logic signed [COORD_WIDTH-1:0] qx, qy, qz;
    pproj_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .NUM_WIDTH(NW)) u_div_x (
        .clk(clk), .adv(adv), .num(dx), .den(dd), .q(qx));
    pproj_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .NUM_WIDTH(NW)) u_div_y (
        .clk(clk), .adv(adv), .num(dy), .den(dd), .q(qy));
    pproj_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .NUM_WIDTH(NW)) u_div_z (
        .clk(clk), .adv(adv), .num(dz), .den(dd), .q(qz));

    logic [DLY-1:0] vld_reg, zf_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DLY-2:0], mv};
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            zf_reg <= {zf_reg[DLY-2:0], zz};
    end

    assign ctl.valid = vld_reg[DLY-1];
    assign out_valid_reg = ctl.valid;
    assign m_axis_tvalid = ctl.valid;
    assign m_axis_tdata = (OUT_BYTES*8)'({zf_reg[DLY-1], qz, qy, qx});
endmodule

// File: verif/perspective_projection_chk.sv
// Checker: watches the config, input and output channels, predicts projections and compares.
`timescale 1ns / 1ps
module perspective_projection_chk
    import pproj_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [REG_WIDTH-1:0]     cfg_data,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [95:0]              s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [103:0]             m_tdata,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic        depth_zero;
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
    } proj_t;

    logic signed [31:0] x_scale, y_scale, z_scale, z_offset;
    proj_t proj_q[$];

    assign pending = proj_q.size();

    function automatic logic [31:0] sat32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -128'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // truncating divide on magnitudes
    function automatic logic [31:0] div_sat(logic signed [127:0] n, logic signed [31:0] d);
        logic [127:0] mn, md, q;
        logic neg;
        neg = n[127] ^ d[31];
        mn = n[127] ? -n : n;
        md = d[31] ? (~{{96{1'b1}}, d} + 128'd1) : {96'd0, d};
        q = mn / md;
        return sat32(neg ? -$signed(q) : $signed(q));
    endfunction

    function automatic proj_t project(logic [95:0] v);
        logic signed [31:0]  x, y, z;
        logic signed [127:0] nx, ny, nz;
        proj_t r;
        x = v[31:0];
        y = v[63:32];
        z = v[95:64];
        nx = 128'(x) * 128'(x_scale);
        ny = 128'(y) * 128'(y_scale);
        nz = 128'(z) * 128'(z_scale) + (128'(z_offset) <<< 16);
        if (z == 0) begin
            r.px = sat32(nx >>> 16);
            r.py = sat32(ny >>> 16);
            r.pz = sat32(nz >>> 16);
            r.depth_zero = 1'b1;
        end
        else begin
            r.px = div_sat(nx, z);
            r.py = div_sat(ny, z);
            r.pz = div_sat(nz, z);
            r.depth_zero = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        proj_t got, want;
        if (!rst_n) begin
            x_scale  <= X_SCALE_RESET;
            y_scale  <= Y_SCALE_RESET;
            z_scale  <= Z_SCALE_RESET;
            z_offset <= Z_OFFSET_RESET;
            fail_count = 0;
            proj_q.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[96:0];
                if (proj_q.size() == 0)
                    report_mismatch("unexpected beat", got.px, 32'd0);
                else begin
                    want = proj_q.pop_front();
                    if (got.px !== want.px) report_mismatch("proj_x", got.px, want.px);
                    if (got.py !== want.py) report_mismatch("proj_y", got.py, want.py);
                    if (got.pz !== want.pz) report_mismatch("proj_z", got.pz, want.pz);
                    if (got.depth_zero !== want.depth_zero)
                        report_mismatch("depth_zero", {31'd0, got.depth_zero},
                                        {31'd0, want.depth_zero});
                end
            end
            if (s_tvalid && s_tready)
                proj_q = {proj_q, project(s_tdata)};
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_X_SCALE:  x_scale  <= cfg_data;
                    REG_Y_SCALE:  y_scale  <= cfg_data;
                    REG_Z_SCALE:  z_scale  <= cfg_data;
                    REG_Z_OFFSET: z_offset <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: verif/perspective_projection_tb.sv
// Testbench top: drives vertices and register writes, gives the verdict.
`timescale 1ns / 1ps
module perspective_projection_tb;
    import pproj_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0]     cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [95:0]              s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [103:0]             m_tdata;
    int                       fail_count;
    int                       pending;
    int                       send_idle = 0;
    int                       recv_stall = 0;
    int                       idle_cycles = 0;

    always #6 clk = ~clk;

    perspective_projection u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
    );

    perspective_projection_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || (pending == 0 && !s_tvalid && !cfg_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL perspective_projection");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom_range(1) ? 32'd1 : 32'hffff_ffff;
            4: return $signed($urandom_range(2000000)) - 32'sd1000000;
            5: return {{16{$urandom_range(1) ? 1'b1 : 1'b0}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    initial begin
        logic [31:0] ext[4];
        ext = '{32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'hffff_ffff};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: extremes, zero depth, unit depth
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_vertex(ext[i], ext[3-j], ext[j]);
        send_vertex(32'h0001_0000, 32'hffff_0000, 32'd0);
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_vertex(32'h1234_5678, 32'hedcb_a988, 32'hffff_0000);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 65; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 9; recv_stall = 9; end
            endcase
            for (int r = 0; r < 4; r++) begin
                logic [31:0] v;
                case (ph)
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'd0;
                    3: v = (r == 3) ? Z_OFFSET_RESET : 32'h0001_0000;
                    default: v = rand_coord();
                endcase
                write_reg(r[CFG_IDX_WIDTH-1:0], v);
            end
            cfg_valid <= 1'b0;
            for (int k = 0; k < 144; k++)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            drain();
        end
        if (fail_count == 0)
            $display("PASS perspective_projection");
        else
            $display("FAIL perspective_projection");
        $finish;
    end

endmodule
